// ===== design/utf8d_pkg.sv =====
package utf8d_pkg;

	// open sequence length codes
	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
	localparam logic [20:0] SURR_LO     = 21'h00D800;
	localparam logic [20:0] SURR_HI     = 21'h00DFFF;
	localparam logic [20:0] MIN_LEN2    = 21'h000080;
	localparam logic [20:0] MIN_LEN3    = 21'h000800;
	localparam logic [20:0] MIN_LEN4    = 21'h010000;

	// payload bits held between bytes: 3 from a 4-byte lead plus two continuations
	localparam int PARTIAL_W = 15;

	// results caused by one byte: rep replacements, then an optional tail result
	typedef struct packed {
		logic [2:0]  rep;
		logic        tail_valid;
		logic [20:0] tail_cp;
		logic        tail_bad;
	} group_t;

endpackage

// ===== design/utf8_codepoint_decoder.sv =====
// the first result of a byte is offered in the cycle after its transfer
// throughput: one byte per cycle while each byte gives at most one result and
// out_ready is high; a byte giving n results (up to 4) holds the result
// register while the single port drains them, one per cycle with out_ready high
// reset clears the open sequence and drops any results not yet delivered
module utf8_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [20:0] code_point,
	output logic        bad_sequence,
	output logic        last_of_run
);
	import utf8d_pkg::*;

	logic [2:0]           len_q;
	logic [1:0]           taken_q;
	logic [PARTIAL_W-1:0] partial_q;
	logic [2:0]           rep_q;
	logic                 tail_valid_q;
	logic [20:0]          tail_cp_q;
	logic                 tail_bad_q;

	logic [2:0]           nxt_len;
	logic [1:0]           nxt_taken;
	logic [PARTIAL_W-1:0] nxt_partial;
	group_t               grp;
	logic                 in_xfer;
	logic                 out_xfer;

	utf8d_decode u_decode (
		.in_byte     (in_byte),
		.len         (len_q),
		.taken       (taken_q),
		.partial     (partial_q),
		.nxt_len     (nxt_len),
		.nxt_taken   (nxt_taken),
		.nxt_partial (nxt_partial),
		.grp         (grp)
	);

	assign out_valid    = (rep_q != 3'd0) || tail_valid_q;
	assign code_point   = (rep_q != 3'd0) ? REPLACEMENT : tail_cp_q;
	assign bad_sequence = (rep_q != 3'd0) ? 1'b1 : tail_bad_q;
	assign last_of_run  = (rep_q == 3'd0) || ((rep_q == 3'd1) && !tail_valid_q);

	// a new byte may enter while the last result of the previous one leaves
	assign in_ready = !out_valid || (out_ready && last_of_run);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= LEN_NONE;
			taken_q      <= 2'd0;
			rep_q        <= 3'd0;
			tail_valid_q <= 1'b0;
		end else if (in_xfer) begin
			len_q        <= nxt_len;
			taken_q      <= nxt_taken;
			rep_q        <= grp.rep;
			tail_valid_q <= grp.tail_valid;
		end else if (out_xfer) begin
			if (rep_q != 3'd0) begin
				rep_q <= rep_q - 3'd1;
			end else begin
				tail_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			partial_q  <= nxt_partial;
			tail_cp_q  <= grp.tail_cp;
			tail_bad_q <= grp.tail_bad;
		end
	end

	// never more than four results pending for one byte
	a_group_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rep_q} + {3'd0, tail_valid_q}) <= 4'd4)
		else $error("more than four results pending");

	// a transfer that is not the last of its run leaves more to deliver
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !last_of_run |=> out_valid)
		else $error("run ended early");

	// open sequence length is a legal code and the byte count stays below it
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == LEN_NONE && taken_q == 2'd0) ||
		((len_q == LEN_2 || len_q == LEN_3 || len_q == LEN_4) &&
		 taken_q != 2'd0 && {1'b0, taken_q} < len_q))
		else $error("inconsistent sequence state");

	// a pending result stays offered, unchanged, until it is taken
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point))
		else $error("pending result lost");

endmodule

// ===== design/utf8d_decode.sv =====
module utf8d_decode (
	input  logic [7:0]                       in_byte,
	input  logic [2:0]                       len,
	input  logic [1:0]                       taken,
	input  logic [utf8d_pkg::PARTIAL_W-1:0]  partial,
	output logic [2:0]                       nxt_len,
	output logic [1:0]                       nxt_taken,
	output logic [utf8d_pkg::PARTIAL_W-1:0]  nxt_partial,
	output utf8d_pkg::group_t                grp
);
	import utf8d_pkg::*;

	logic        cont;
	logic [20:0] v;
	logic [2:0]  taken_inc;
	logic [20:0] min_val;
	logic        out_of_range;
	logic        start;

	assign cont      = (in_byte[7:6] == 2'b10);
	assign v         = {partial, in_byte[5:0]};
	assign taken_inc = {1'b0, taken} + 3'd1;

	always_comb begin
		unique case (len)
			LEN_2:   min_val = MIN_LEN2;
			LEN_3:   min_val = MIN_LEN3;
			default: min_val = MIN_LEN4;
		endcase
	end

	// overlong, above the last scalar, or a surrogate
	assign out_of_range = (v < min_val) || (v > MAX_SCALAR) ||
		((v >= SURR_LO) && (v <= SURR_HI));

	always_comb begin
		nxt_len     = len;
		nxt_taken   = taken;
		nxt_partial = partial;
		grp         = '0;
		start       = 1'b0;
		if (len != LEN_NONE) begin
			if (in_byte == 8'h00) begin
				// end of string flushes the open sequence
				grp.rep   = {1'b0, taken};
				nxt_len   = LEN_NONE;
				nxt_taken = 2'd0;
			end else if (cont) begin
				if (taken_inc >= len) begin
					if (out_of_range) begin
						grp.rep = len;
					end else begin
						grp.tail_valid = 1'b1;
						grp.tail_cp    = v;
					end
					nxt_len   = LEN_NONE;
					nxt_taken = 2'd0;
				end else begin
					nxt_taken   = taken_inc[1:0];
					nxt_partial = v[PARTIAL_W-1:0];
				end
			end else begin
				// bad continuation: replace what was taken, rescan this byte
				grp.rep   = {1'b0, taken};
				nxt_len   = LEN_NONE;
				nxt_taken = 2'd0;
				start     = 1'b1;
			end
		end else if (in_byte != 8'h00) begin
			start = 1'b1;
		end

		if (start) begin
			priority if (in_byte[7] == 1'b0) begin
				grp.tail_valid = 1'b1;
				grp.tail_cp    = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				nxt_len     = LEN_2;
				nxt_taken   = 2'd1;
				nxt_partial = {{(PARTIAL_W-5){1'b0}}, in_byte[4:0]};
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt_len     = LEN_3;
				nxt_taken   = 2'd1;
				nxt_partial = {{(PARTIAL_W-4){1'b0}}, in_byte[3:0]};
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt_len     = LEN_4;
				nxt_taken   = 2'd1;
				nxt_partial = {{(PARTIAL_W-3){1'b0}}, in_byte[2:0]};
			end else begin
				// stray continuation or invalid lead
				grp.tail_valid = 1'b1;
				grp.tail_cp    = REPLACEMENT;
				grp.tail_bad   = 1'b1;
			end
		end
	end

endmodule
